// ===== sv/ffp_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ffp_pkg
// widths and constants shared by the fermat factor search block
// ----------------------------------------------------------------------------
package ffp_pkg;

  localparam int N_WIDTH = 32;
  localparam int OUT_W   = 32;
  localparam int ROOT_W  = (N_WIDTH + 1) / 2;
  localparam int SQ_W    = 2 * ROOT_W;
  localparam int SUB_W   = SQ_W + 1;
  localparam int CNT_W   = $clog2(N_WIDTH);

endpackage
`default_nettype wire

// ===== sv/ffp_num_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ffp_num_if
// valid/ready channel that carries one number to factor
// ----------------------------------------------------------------------------
interface ffp_num_if;
  import ffp_pkg::*;

  logic               valid;
  logic               ready;
  logic [N_WIDTH-1:0] number;

  modport source (output valid, output number, input ready);
  modport sink (input valid, input number, output ready);
endinterface
`default_nettype wire

// ===== sv/ffp_fact_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ffp_fact_if
// valid/ready channel that carries one factor search result
// ----------------------------------------------------------------------------
interface ffp_fact_if;
  import ffp_pkg::*;

  logic             valid;
  logic             ready;
  logic             no_factor_found;
  logic [OUT_W-1:0] small_factor;
  logic [OUT_W-1:0] large_factor;

  modport source (output valid, output no_factor_found, output small_factor,
                  output large_factor, input ready);
  modport sink (input valid, input no_factor_found, input small_factor,
                input large_factor, output ready);
endinterface
`default_nettype wire

// ===== sv/fermat_factor_primality.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fermat_factor_primality
// finds the factor pair a*b = n of equal parity with the largest a >= 2
// ----------------------------------------------------------------------------
// One number is taken per transaction and one result is returned. The block
// first takes the integer square root of n, then tries each candidate a from
// that root down to 2 with a restoring divider (S_DIV) and a check state
// (S_CHECK) per candidate. A single subtract/compare unit serves both the
// root and the divider. A search ends soonest when a large factor lies near
// the root and runs through every candidate for a prime. The block takes no
// new number while a search runs; a finished result waits in an output
// register until taken. Zero reports a pair of zeros; numbers with no
// equal-parity pair (primes, two mod four) report no_factor_found with both
// factors zero.
module fermat_factor_primality (
  input  wire logic clk,
  input  wire logic rst,
  ffp_num_if.sink   request,
  ffp_fact_if.source result
);
  import ffp_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SQRT,
    S_DIV,
    S_CHECK,
    S_FINISH
  } state_t;

  state_t             state;
  logic [N_WIDTH-1:0] n_reg;
  logic [SQ_W-1:0]    v;
  logic [SQ_W-1:0]    root;
  logic [SQ_W-1:0]    bit_mask;
  logic [ROOT_W-1:0]  a;
  logic [ROOT_W:0]    rem;
  logic [N_WIDTH-1:0] dvd;
  logic [CNT_W-1:0]   cnt;
  logic               found;
  logic [OUT_W-1:0]   small_val;
  logic [OUT_W-1:0]   large_val;
  logic               res_found;
  logic [OUT_W-1:0]   res_small;
  logic [OUT_W-1:0]   res_large;

  logic [SUB_W-1:0]   sub_a;
  logic [SUB_W-1:0]   sub_b;
  logic [SUB_W:0]     diff;
  logic               ge;
  logic [ROOT_W:0]    trial;
  logic [SQ_W-1:0]    root_next;
  logic [SQ_W-1:0]    bit_next;
  logic [ROOT_W-1:0]  root_a;
  logic               load_result;

  // shared subtract and compare unit
  always_comb begin
    trial = {rem[ROOT_W-1:0], dvd[N_WIDTH-1]};
    if (state == S_SQRT) begin
      sub_a = SUB_W'(v);
      sub_b = SUB_W'(root) + SUB_W'(bit_mask);
    end else begin
      sub_a = SUB_W'(trial);
      sub_b = SUB_W'(a);
    end
    diff = {1'b0, sub_a} - {1'b0, sub_b};
    ge   = ~diff[SUB_W];
    if (ge) begin
      root_next = (root >> 1) + bit_mask;
    end else begin
      root_next = root >> 1;
    end
    bit_next = bit_mask >> 2;
    root_a   = root_next[ROOT_W-1:0];
  end

  assign load_result            = (state == S_FINISH) && (!result.valid || result.ready);
  assign request.ready          = (state == S_IDLE);
  assign result.no_factor_found = ~res_found;
  assign result.small_factor    = res_small;
  assign result.large_factor    = res_large;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result.valid <= 1'b0;
    end else begin
      if (load_result) begin
        result.valid <= 1'b1;
      end else if (result.valid && result.ready) begin
        result.valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (request.valid) begin
            n_reg    <= request.number;
            v        <= SQ_W'(request.number);
            root     <= '0;
            bit_mask <= SQ_W'(1) << (SQ_W - 2);
            if (request.number == '0) begin
              found     <= 1'b1;
              small_val <= '0;
              large_val <= '0;
              state     <= S_FINISH;
            end else begin
              state <= S_SQRT;
            end
          end
        end
        S_SQRT: begin
          if (ge) begin
            v <= diff[SQ_W-1:0];
          end
          root     <= root_next;
          bit_mask <= bit_next;
          if (bit_next == '0) begin
            a   <= root_a;
            rem <= '0;
            dvd <= n_reg;
            cnt <= '0;
            if (root_a < ROOT_W'(2)) begin
              found     <= 1'b0;
              small_val <= '0;
              large_val <= '0;
              state     <= S_FINISH;
            end else begin
              state <= S_DIV;
            end
          end
        end
        S_DIV: begin
          if (ge) begin
            rem <= diff[ROOT_W:0];
          end else begin
            rem <= trial;
          end
          dvd <= {dvd[N_WIDTH-2:0], ge};
          cnt <= cnt + CNT_W'(1);
          if (cnt == CNT_W'(N_WIDTH - 1)) begin
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (rem == '0 && a[0] == dvd[0]) begin
            found     <= 1'b1;
            small_val <= OUT_W'(a);
            large_val <= OUT_W'(dvd);
            state     <= S_FINISH;
          end else if (a == ROOT_W'(2)) begin
            found     <= 1'b0;
            small_val <= '0;
            large_val <= '0;
            state     <= S_FINISH;
          end else begin
            a     <= a - ROOT_W'(1);
            rem   <= '0;
            dvd   <= n_reg;
            cnt   <= '0;
            state <= S_DIV;
          end
        end
        S_FINISH: begin
          if (load_result) begin
            res_found <= found;
            res_small <= small_val;
            res_large <= large_val;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire
